@@ rtl/cppm_pkg.sv @@
// Shared types, constants and event codes for the CPPM channel decoder.
// No dependencies; imported by every module of the decoder.
`timescale 1ns / 1ps

package cppm_pkg;

  // Sizing
  localparam int MAX_CHANNELS = 16;
  localparam int WIDTH_BITS   = 16;
  localparam int CH_IDX_W     = $clog2(MAX_CHANNELS);
  localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
  localparam int AGE_W        = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;

  localparam logic [WIDTH_BITS-1:0] GAP_MAX = {WIDTH_BITS{1'b1}};
  localparam logic [AGE_W-1:0]      AGE_MAX = {AGE_W{1'b1}};
  localparam logic [CNT_W-1:0]      CH_LIMIT = CNT_W'(MAX_CHANNELS);

  // Register reset values
  localparam logic [CNT_W-1:0]      RST_CHANNEL_COUNT  = CNT_W'(8);
  localparam logic [WIDTH_BITS-1:0] RST_MIN_WIDTH      = WIDTH_BITS'(1000);
  localparam logic [WIDTH_BITS-1:0] RST_MAX_WIDTH      = WIDTH_BITS'(2000);
  localparam logic [WIDTH_BITS-1:0] RST_DEFAULT_WIDTH  = WIDTH_BITS'(1500);
  localparam logic [WIDTH_BITS-1:0] RST_SYNC_THRESHOLD = WIDTH_BITS'(3000);
  localparam logic [AGE_W-1:0]      RST_TIMEOUT_TICKS  = AGE_W'(100000);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 3'd5;

  // Item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_STORED  = 2'd1;
  localparam logic [1:0] EV_SYNC    = 2'd2;
  localparam logic [1:0] EV_IGNORED = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0]      channel_count;
    logic [WIDTH_BITS-1:0] min_width;
    logic [WIDTH_BITS-1:0] max_width;
    logic [WIDTH_BITS-1:0] default_width;
    logic [WIDTH_BITS-1:0] sync_threshold;
    logic [AGE_W-1:0]      timeout_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic                  en;
    logic [WIDTH_BITS-1:0] value;
  } fill_t;

  typedef struct packed {
    logic                kind;
    logic                pin_level;
    logic [CH_IDX_W-1:0] read_channel;
  } item_t;

  typedef struct packed {
    logic [1:0]            event_res;
    logic [CH_IDX_W-1:0]   event_channel;
    logic [WIDTH_BITS-1:0] event_width;
    logic [WIDTH_BITS-1:0] read_value;
    logic                  receiving;
    logic [AGE_W-1:0]      frame_age;
  } result_t;

endpackage

@@ rtl/cppm_cfg_regs.sv @@
// Configuration register file of the CPPM decoder.
// Depends on cppm_pkg; issues a store refill strobe when default_width is written.
`timescale 1ns / 1ps

module cppm_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cppm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cppm_pkg::CFG_DATA_W-1:0] cfg_data,
  output cppm_pkg::cfg_regs_t            regs,
  output cppm_pkg::fill_t                fill
);
  import cppm_pkg::*;

  cfg_regs_t regs_r, regs_nxt;
  logic      wr_en;

  // Writes are always taken
  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid & cfg_ready;

  // Address decode
  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (cfg_index)
        REG_CHANNEL_COUNT:  regs_nxt.channel_count  = cfg_data[CNT_W-1:0];
        REG_MIN_WIDTH:      regs_nxt.min_width      = cfg_data[WIDTH_BITS-1:0];
        REG_MAX_WIDTH:      regs_nxt.max_width      = cfg_data[WIDTH_BITS-1:0];
        REG_DEFAULT_WIDTH:  regs_nxt.default_width  = cfg_data[WIDTH_BITS-1:0];
        REG_SYNC_THRESHOLD: regs_nxt.sync_threshold = cfg_data[WIDTH_BITS-1:0];
        REG_TIMEOUT_TICKS:  regs_nxt.timeout_ticks  = cfg_data[AGE_W-1:0];
        default:            regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.channel_count  <= RST_CHANNEL_COUNT;
      regs_r.min_width      <= RST_MIN_WIDTH;
      regs_r.max_width      <= RST_MAX_WIDTH;
      regs_r.default_width  <= RST_DEFAULT_WIDTH;
      regs_r.sync_threshold <= RST_SYNC_THRESHOLD;
      regs_r.timeout_ticks  <= RST_TIMEOUT_TICKS;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

  // Refill strobe goes out in the same cycle as the write
  assign fill.en    = wr_en && (cfg_index == REG_DEFAULT_WIDTH);
  assign fill.value = cfg_data[WIDTH_BITS-1:0];

endmodule

@@ rtl/cppm_core.sv @@
// Decode state (gap/age counters, channel index, channel store) and the
// per-item next-state and result logic. Depends on cppm_pkg.
`timescale 1ns / 1ps

module cppm_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  cppm_pkg::item_t     item,
  input  cppm_pkg::cfg_regs_t regs,
  input  cppm_pkg::fill_t     fill,
  output cppm_pkg::result_t   res
);
  import cppm_pkg::*;

  logic [WIDTH_BITS-1:0] gap_r, gap_nxt;
  logic                  last_r, last_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [AGE_W-1:0]      age_r, age_nxt;
  logic                  recv_r, recv_nxt;
  logic [WIDTH_BITS-1:0] store_r [MAX_CHANNELS];

  logic [CNT_W-1:0]      active_n;
  logic [WIDTH_BITS-1:0] gap_inc;
  logic [WIDTH_BITS-1:0] clamped;
  logic                  wr_en;

  // Channel count with zero acting as one and large values as the limit
  always_comb begin
    if (regs.channel_count == '0) begin
      active_n = CNT_W'(1);
    end else if (regs.channel_count > CH_LIMIT) begin
      active_n = CH_LIMIT;
    end else begin
      active_n = regs.channel_count;
    end
  end

  // Saturating gap and clamp of the measured pulse width
  assign gap_inc = (gap_r == GAP_MAX) ? GAP_MAX : gap_r + 1'b1;

  always_comb begin
    if (gap_inc < regs.min_width) begin
      clamped = regs.min_width;
    end else if (gap_inc > regs.max_width) begin
      clamped = regs.max_width;
    end else begin
      clamped = gap_inc;
    end
  end

  // Next state and result for one item
  always_comb begin
    gap_nxt  = gap_r;
    last_nxt = last_r;
    idx_nxt  = idx_r;
    age_nxt  = age_r;
    recv_nxt = recv_r;
    wr_en    = 1'b0;
    res      = '0;

    if (item.kind == KIND_READ) begin
      if ({1'b0, item.read_channel} < active_n) begin
        res.read_value = store_r[item.read_channel];
      end else begin
        res.read_value = regs.default_width;
      end
    end else begin
      gap_nxt = gap_inc;
      age_nxt = (age_r == AGE_MAX) ? AGE_MAX : age_r + 1'b1;
      // falling edge closes a gap
      if (last_r && !item.pin_level) begin
        gap_nxt = '0;
        if (gap_inc > regs.sync_threshold) begin
          age_nxt       = '0;
          idx_nxt       = '0;
          recv_nxt      = 1'b1;
          res.event_res = EV_SYNC;
        end else begin
          if (idx_r < active_n) begin
            wr_en             = 1'b1;
            res.event_res     = EV_STORED;
            res.event_channel = idx_r[CH_IDX_W-1:0];
            res.event_width   = clamped;
          end else begin
            res.event_res = EV_IGNORED;
          end
          if (idx_r < CH_LIMIT) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      last_nxt = item.pin_level;
      if (age_nxt > regs.timeout_ticks) begin
        recv_nxt = 1'b0;
      end
    end

    res.receiving = recv_nxt;
    res.frame_age = age_nxt;
  end

  // Counters and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r  <= '0;
      last_r <= 1'b1;
      idx_r  <= '0;
      age_r  <= '0;
      recv_r <= 1'b0;
    end else if (step_en) begin
      gap_r  <= gap_nxt;
      last_r <= last_nxt;
      idx_r  <= idx_nxt;
      age_r  <= age_nxt;
      recv_r <= recv_nxt;
    end
  end

  // Channel store: refill on default_width write, else one entry per stored pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        store_r[i] <= RST_DEFAULT_WIDTH;
      end
    end else if (fill.en) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        store_r[i] <= fill.value;
      end
    end else if (step_en && wr_en) begin
      store_r[idx_r[CH_IDX_W-1:0]] <= clamped;
    end
  end

endmodule

@@ rtl/cppm_channel_decoder.sv @@
// CPPM channel decoder: one result per item; each item passes the input register, then
// the result register, before out_valid rises; one transaction per cycle unless the output stalls.
// in_ready stays high while the input register is empty or its item moves on; a
// result waiting at the output holds the item behind it, and then in_ready drops.
// Reset (rst_n low, synchronous) empties both stages, loads register defaults
// and fills every channel entry with the default width in the same cycle.
`timescale 1ns / 1ps

module cppm_channel_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic                              in_pin_level,
  input  logic [cppm_pkg::CH_IDX_W-1:0]     in_read_channel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_event_res,
  output logic [cppm_pkg::CH_IDX_W-1:0]     out_event_channel,
  output logic [cppm_pkg::WIDTH_BITS-1:0]   out_event_width,
  output logic [cppm_pkg::WIDTH_BITS-1:0]   out_read_value,
  output logic                              out_receiving,
  output logic [cppm_pkg::AGE_W-1:0]        out_frame_age,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cppm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cppm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cppm_pkg::*;

  cfg_regs_t regs;
  fill_t     fill;
  item_t     item_r;
  result_t   res, res_r;
  logic      in_vld_r, in_vld_nxt;
  logic      out_vld_r, out_vld_nxt;
  logic      out_adv;
  logic      step_en;

  cppm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs),
    .fill      (fill)
  );

  cppm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .regs    (regs),
    .fill    (fill),
    .res     (res)
  );

  // Pipeline flow control
  assign out_adv  = !out_vld_r || out_ready;
  assign step_en  = in_vld_r && out_adv;
  assign in_ready = !in_vld_r || out_adv;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (step_en) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_adv ? step_en : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.kind         <= in_kind;
      item_r.pin_level    <= in_pin_level;
      item_r.read_channel <= in_read_channel;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_event_res     = res_r.event_res;
  assign out_event_channel = res_r.event_channel;
  assign out_event_width   = res_r.event_width;
  assign out_read_value    = res_r.read_value;
  assign out_receiving     = res_r.receiving;
  assign out_frame_age     = res_r.frame_age;

endmodule

@@ rtl/cppm_checker.sv @@
// Port-level checks for the CPPM channel decoder, bound to the top level.
// Depends on cppm_pkg for sizes and event codes.
`timescale 1ns / 1ps

module cppm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_kind,
  input logic                              in_pin_level,
  input logic [cppm_pkg::CH_IDX_W-1:0]     in_read_channel,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [1:0]                        out_event_res,
  input logic [cppm_pkg::CH_IDX_W-1:0]     out_event_channel,
  input logic [cppm_pkg::WIDTH_BITS-1:0]   out_event_width,
  input logic [cppm_pkg::WIDTH_BITS-1:0]   out_read_value,
  input logic                              out_receiving,
  input logic [cppm_pkg::AGE_W-1:0]        out_frame_age,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [cppm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [cppm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cppm_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res)
      && $stable(out_read_value) && $stable(out_frame_age)
      && $stable(out_event_width))
    else $error("result changed while stalled");

  // Channel and width are only reported with a stored pulse
  a_event_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res != EV_STORED)
      |-> (out_event_channel == '0) && (out_event_width == '0))
    else $error("event fields set without a stored pulse");

  // A sync restarts the frame age and raises receiving
  a_sync: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_SYNC) |-> (out_frame_age == '0) && out_receiving)
    else $error("sync without age restart or receiving");

  // Read values come only from read transactions, which carry no event
  a_read_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_value != '0) |-> (out_event_res == EV_NONE))
    else $error("read value together with a pulse event");

endmodule

bind cppm_channel_decoder cppm_checker u_cppm_checker (.*);
